// ----- hdl/bafmt_pkg.sv -----
// bafmt_pkg: widths, format codes, character constants and the power-of-ten table
// for the number formatter. No dependencies; imported by bafmt_core and the top level.
package bafmt_pkg;

	localparam int VALUE_WIDTH = 16;

	// number of hex digits and the width of the shift register that holds them
	localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
	localparam int HEX_W      = HEX_DIGITS * 4;

	// decimal digits needed for the largest value
	function automatic int dec_digit_count();
		logic [63:0] p;
		logic [63:0] vmax;
		int          n;
		vmax = (64'd1 << VALUE_WIDTH) - 64'd1;
		p    = 64'd10;
		n    = 1;
		while (p <= vmax) begin
			p = p * 64'd10;
			n = n + 1;
		end
		return n;
	endfunction

	localparam int DEC_DIGITS = dec_digit_count();
	localparam int DIG_W      = (DEC_DIGITS > 1) ? $clog2(DEC_DIGITS) : 1;
	localparam int CNT_W      = $clog2(VALUE_WIDTH);

	typedef logic [VALUE_WIDTH-1:0] val_t;
	typedef val_t pow10_arr_t [DEC_DIGITS];

	// entry 0 holds the highest power
	function automatic pow10_arr_t make_pow10();
		pow10_arr_t  p;
		logic [63:0] acc;
		acc = 64'd1;
		for (int k = DEC_DIGITS - 1; k >= 0; k--) begin
			p[k] = val_t'(acc);
			acc  = acc * 64'd10;
		end
		return p;
	endfunction

	localparam pow10_arr_t POW10 = make_pow10();

	localparam logic [7:0] ASCII_ZERO     = 8'd48;
	localparam logic [7:0] ASCII_ONE      = 8'd49;
	localparam logic [7:0] HEX_LETTER_GAP = 8'd7;
	localparam logic [7:0] CHAR_CR        = 8'd13;
	localparam logic [7:0] CHAR_LF        = 8'd10;

	typedef enum logic [1:0] {
		KIND_RAW = 2'd0,
		KIND_BIN = 2'd1,
		KIND_DEC = 2'd2,
		KIND_HEX = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RAW,
		ST_BIN,
		ST_DEC,
		ST_HEX,
		ST_CR,
		ST_LF
	} state_t;

	// one character on its way from the sequencer to the output register
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} chr_t;

endpackage

// ----- hdl/bafmt_core.sv -----
// bafmt_core: sequencer and shared shift / subtract datapath that turns one value
// into a run of ASCII characters, one per cycle at most. Depends on bafmt_pkg.
module bafmt_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [bafmt_pkg::VALUE_WIDTH-1:0] value,
	input  logic [1:0]                   kind,
	input  logic                         emit_ok,
	output logic                         busy,
	output logic                         emit,
	output bafmt_pkg::chr_t              chr
);
	import bafmt_pkg::*;

	state_t              state_q, state_d;
	logic [HEX_W-1:0]    val_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [3:0]          dig_q;
	logic                started_q;

	logic [3:0]          nib;
	logic [7:0]          hex_chr;
	val_t                rem;
	val_t                pw;
	logic [VALUE_WIDTH:0] diff;
	logic                ge;
	logic                hex_end;
	logic                dec_end;
	logic                bin_end;

	logic                shift1, shift4, sub_en, cnt_inc, dig_inc, dig_clr, set_started;

	assign nib     = val_q[HEX_W-1 -: 4];
	assign hex_chr = {4'b0, nib} + ((nib > 4'd9) ? (ASCII_ZERO + HEX_LETTER_GAP) : ASCII_ZERO);
	assign rem     = val_q[VALUE_WIDTH-1:0];
	assign pw      = POW10[cnt_q[DIG_W-1:0]];
	// shared subtractor: borrow out is the compare
	assign diff    = {1'b0, rem} - {1'b0, pw};
	assign ge      = ~diff[VALUE_WIDTH];
	assign hex_end = (cnt_q == CNT_W'(HEX_DIGITS - 1));
	assign dec_end = (cnt_q == CNT_W'(DEC_DIGITS - 1));
	assign bin_end = (cnt_q == CNT_W'(VALUE_WIDTH - 1));
	assign busy    = (state_q != ST_IDLE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (kind_t'(kind))
						KIND_RAW: state_d = ST_RAW;
						KIND_BIN: state_d = ST_BIN;
						KIND_DEC: state_d = ST_DEC;
						KIND_HEX: state_d = ST_HEX;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_RAW:  if (emit) state_d = ST_IDLE;
			ST_BIN:  if (emit && bin_end) state_d = ST_CR;
			ST_HEX:  if (emit && hex_end) state_d = ST_CR;
			ST_DEC:  if (emit && dec_end) state_d = ST_IDLE;
			ST_CR:   if (emit) state_d = ST_LF;
			ST_LF:   if (emit) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath controls
	always_comb begin
		emit          = 1'b0;
		chr.character = ASCII_ZERO;
		chr.last      = 1'b0;
		shift1        = 1'b0;
		shift4        = 1'b0;
		sub_en        = 1'b0;
		cnt_inc       = 1'b0;
		dig_inc       = 1'b0;
		dig_clr       = 1'b0;
		set_started   = 1'b0;
		case (state_q)
			ST_IDLE: begin
			end
			ST_RAW: begin
				chr.character = val_q[7:0];
				chr.last      = 1'b1;
				emit          = emit_ok;
			end
			ST_BIN: begin
				chr.character = val_q[VALUE_WIDTH-1] ? ASCII_ONE : ASCII_ZERO;
				emit          = emit_ok;
				shift1        = emit_ok;
				cnt_inc       = emit_ok;
			end
			ST_HEX: begin
				if (nib == 4'd0 && !started_q && !hex_end) begin
					// leading zero, drop it
					shift4  = 1'b1;
					cnt_inc = 1'b1;
				end else begin
					chr.character = hex_chr;
					emit          = emit_ok;
					shift4        = emit_ok;
					cnt_inc       = emit_ok;
					set_started   = emit_ok;
				end
			end
			ST_DEC: begin
				if (ge) begin
					sub_en  = 1'b1;
					dig_inc = 1'b1;
				end else if (dig_q == 4'd0 && !started_q && !dec_end) begin
					cnt_inc = 1'b1;
				end else begin
					chr.character = ASCII_ZERO + {4'b0, dig_q};
					chr.last      = dec_end;
					emit          = emit_ok;
					cnt_inc       = emit_ok;
					dig_clr       = emit_ok;
					set_started   = emit_ok;
				end
			end
			ST_CR: begin
				chr.character = CHAR_CR;
				emit          = emit_ok;
			end
			ST_LF: begin
				chr.character = CHAR_LF;
				chr.last      = 1'b1;
				emit          = emit_ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			dig_q     <= '0;
			started_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start && !busy) begin
				cnt_q     <= '0;
				dig_q     <= '0;
				started_q <= 1'b0;
			end else begin
				if (cnt_inc) cnt_q <= cnt_q + CNT_W'(1);
				if (dig_clr) dig_q <= '0;
				else if (dig_inc) dig_q <= dig_q + 4'd1;
				if (set_started) started_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			val_q <= HEX_W'(value);
		end else if (shift1) begin
			val_q <= {val_q[HEX_W-2:0], 1'b0};
		end else if (shift4) begin
			val_q <= {val_q[HEX_W-5:0], 4'b0};
		end else if (sub_en) begin
			val_q <= HEX_W'(diff[VALUE_WIDTH-1:0]);
		end
	end

endmodule

// ----- hdl/binary_to_ascii_number_formatter_unit.sv -----
// binary_to_ascii_number_formatter_unit: top level, input handshake and output register
// around the formatting sequencer. Depends on bafmt_pkg and bafmt_core.
//
//   channel  direction  payload            handshake
//   in       receive    value, kind        in_valid / in_stall
//   out      send       character, last    out_valid / out_stall
//
// the accepting cycle itself produces nothing; raw then sends one character, binary
// sends VALUE_WIDTH digits then CR and LF, and hex steps one nibble a cycle while
// out_stall does not hold a printed nibble, skipped leading zeros included, then CR and LF
// decimal skips each leading zero; each other digit is found by repeated subtraction
// of a power of ten in one shared subtractor and then sent as a character
// in_stall stays high from acceptance until the last character enters the output register
// out_stall holds a valid output register and pauses the sequencer's characters; reset empties both
module binary_to_ascii_number_formatter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bafmt_pkg::VALUE_WIDTH-1:0] value,
	input  logic [1:0]                        kind,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [7:0]                        character,
	output logic                              last
);
	import bafmt_pkg::*;

	logic  busy;
	logic  core_emit;
	logic  emit_ok;
	chr_t  core_chr;
	logic  out_valid_q;
	chr_t  out_q;

	assign emit_ok = !out_valid_q || !out_stall;

	bafmt_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_valid),
		.value   (value),
		.kind    (kind),
		.emit_ok (emit_ok),
		.busy    (busy),
		.emit    (core_emit),
		.chr     (core_chr)
	);

	assign in_stall = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_emit) out_q <= core_chr;
	end

	assign out_valid = out_valid_q;
	assign character = out_q.character;
	assign last      = out_q.last;

	// an accepted transaction always keeps the input side busy in the cycle after acceptance
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepted transaction");

	// nothing is produced while idle
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !core_emit)
		else $error("character produced while idle");

	// a run that has not reached its final character keeps the block busy
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		(core_emit && !core_chr.last) |=> in_stall)
		else $error("block went idle in the middle of a run");

endmodule

// ----- tb/sv/tb_binary_to_ascii_number_formatter_unit.sv -----
`timescale 1ns / 1ps
// tb_binary_to_ascii_number_formatter_unit: self-checking bench for the number formatter.
// A directed table and random values are checked character by character against a predictor.
// Depends on bafmt_pkg and binary_to_ascii_number_formatter_unit.
module tb_binary_to_ascii_number_formatter_unit;
	import bafmt_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int RANDOM_ITEMS = 188;
	localparam int BLOCK_ITEMS  = 30;
	localparam int DRAIN_CYCLES = 80;
	localparam val_t CORNERS [12] = '{16'd0, 16'd1, 16'd9, 16'd10, 16'd15, 16'd16, 16'd99,
		16'd100, 16'd9999, 16'd10000, 16'h8000, 16'hFFFF};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	val_t       value;
	logic [1:0] kind;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] character;
	logic       last;

	chr_t       pending_chars [$];
	logic [7:0] run_chars [$];
	val_t       tbl_value [$];
	kind_t      tbl_kind [$];
	string      tbl_text [$];
	bit         no_idle;
	int         errors;
	int         idle_cycles;

	binary_to_ascii_number_formatter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.kind      (kind),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.character (character),
		.last      (last)
	);

	always #5 clk = ~clk;

	// digits of num in the given radix, most significant first, no leading zeros
	task automatic push_digits(input logic [31:0] num, input logic [31:0] radix);
		logic [7:0] digits [$];
		logic [7:0] d;
		do begin
			d = 8'(num % radix);
			num = num / radix;
			if (d > 8'd9)
				d = d + HEX_LETTER_GAP;
			digits.push_front(d + ASCII_ZERO);
		end while (num != 0);
		foreach (digits[i])
			run_chars.push_back(digits[i]);
	endtask

	task automatic format_number(input val_t v, input kind_t k);
		run_chars.delete();
		case (k)
			KIND_RAW: begin
				run_chars.push_back(v[7:0]);
			end
			KIND_BIN: begin
				for (int i = VALUE_WIDTH - 1; i >= 0; i--)
					run_chars.push_back(v[i] ? ASCII_ONE : ASCII_ZERO);
				run_chars.push_back(CHAR_CR);
				run_chars.push_back(CHAR_LF);
			end
			KIND_DEC: begin
				push_digits(32'(v), 32'd10);
			end
			default: begin
				push_digits(32'(v), 32'd16);
				run_chars.push_back(CHAR_CR);
				run_chars.push_back(CHAR_LF);
			end
		endcase
	endtask

	// move the scratch run into the expected characters, flagging its final one
	task automatic commit_run();
		foreach (run_chars[i])
			pending_chars.push_back('{character: run_chars[i],
				last: (i == run_chars.size() - 1)});
	endtask

	task automatic add_row(input val_t v, input kind_t k, input string text);
		tbl_value.push_back(v);
		tbl_kind.push_back(k);
		tbl_text.push_back(text);
	endtask

	// returns just after the edge at which the transaction was taken
	task automatic send_number(input val_t v, input kind_t k);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		kind     <= k;
		do @(negedge clk); while (in_stall !== 1'b0);
		@(posedge clk);
	endtask

	task automatic wait_all_received();
		while (pending_chars.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		val_t  v;
		kind_t k;
		clk       = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		value     = '0;
		kind      = KIND_RAW;
		out_stall = 1'b0;
		no_idle   = 1'b0;
		errors    = 0;

		add_row(16'h0041, KIND_RAW, "A");
		add_row(16'h1234, KIND_RAW, "4");
		add_row(16'hFFFF, KIND_RAW, "\377");
		add_row(16'h0000, KIND_RAW, "");
		add_row(16'h0000, KIND_BIN, "0000000000000000\r\n");
		add_row(16'hFFFF, KIND_BIN, "1111111111111111\r\n");
		add_row(16'h8001, KIND_BIN, "1000000000000001\r\n");
		add_row(16'hA5C3, KIND_BIN, "");
		add_row(16'd0,     KIND_DEC, "0");
		add_row(16'd9,     KIND_DEC, "9");
		add_row(16'd10,    KIND_DEC, "10");
		add_row(16'd9999,  KIND_DEC, "9999");
		add_row(16'd10000, KIND_DEC, "10000");
		add_row(16'd65535, KIND_DEC, "65535");
		add_row(16'd100,   KIND_DEC, "");
		add_row(16'd12345, KIND_DEC, "");
		add_row(16'h0000, KIND_HEX, "0\r\n");
		add_row(16'h000A, KIND_HEX, "A\r\n");
		add_row(16'h1000, KIND_HEX, "1000\r\n");
		add_row(16'hFFFF, KIND_HEX, "FFFF\r\n");
		add_row(16'h00F0, KIND_HEX, "");
		add_row(16'hBEEF, KIND_HEX, "");

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (tbl_value[i]) begin
			no_idle = (i >= tbl_value.size() / 2);
			send_number(tbl_value[i], tbl_kind[i]);
			if (tbl_text[i] != "") begin
				run_chars.delete();
				for (int c = 0; c < tbl_text[i].len(); c++)
					run_chars.push_back(tbl_text[i][c]);
			end else begin
				format_number(tbl_value[i], tbl_kind[i]);
			end
			commit_run();
		end
		in_valid <= 1'b0;

		// hold off until the output side has caught up completely
		wait_all_received();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % BLOCK_ITEMS == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			case ($urandom_range(0, 3))
				0:       v = val_t'($urandom_range(0, 15));
				1:       v = CORNERS[$urandom_range(0, 11)];
				default: v = val_t'($urandom);
			endcase
			k = kind_t'($urandom_range(0, 3));
			send_number(v, k);
			format_number(v, k);
			commit_run();
		end
		in_valid <= 1'b0;

		wait_all_received();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_chars.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : receive_side
		int   hold;
		chr_t got;
		chr_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(negedge clk); while (out_valid !== 1'b1);
			got = '{character: character, last: last};
			@(posedge clk);
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected transaction, character %h last %b",
					$time, got.character, got.last);
				errors++;
			end else begin
				want = pending_chars.pop_front();
				if (got.character !== want.character) begin
					$display("%0t: character expected %h got %h",
						$time, want.character, got.character);
					errors++;
				end
				if (got.last !== want.last) begin
					$display("%0t: last expected %b got %b", $time, want.last, got.last);
					errors++;
				end
			end
		end
	end

	// cycles in which neither channel moves a transaction
	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ----- files.f -----
hdl/bafmt_pkg.sv
hdl/bafmt_core.sv
hdl/binary_to_ascii_number_formatter_unit.sv
tb/sv/tb_binary_to_ascii_number_formatter_unit.sv
